FILE: hw/rtl/svpwm_sector_duty_calc_core_macros.svh
// Assertion macros shared by the SVPWM duty calculator RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef SVPWM_SECTOR_DUTY_CALC_CORE_MACROS_SVH
`define SVPWM_SECTOR_DUTY_CALC_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SVPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svpwm assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SVPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svpwm assertion failed");

`endif

FILE: hw/rtl/svpwm_pkg.sv
// Package for the SVPWM sector and duty calculator.
// Holds fixed-point constants, register indexes and sector codes; no dependencies.
`default_nettype none

package svpwm_pkg;

  localparam int unsigned SECTOR_W = 3;
  typedef logic [SECTOR_W-1:0] sector_t;

  localparam sector_t SECTOR_NONE    = 3'd0;
  localparam sector_t SECTOR_1       = 3'd1;
  localparam sector_t SECTOR_2       = 3'd2;
  localparam sector_t SECTOR_3       = 3'd3;
  localparam sector_t SECTOR_4       = 3'd4;
  localparam sector_t SECTOR_5       = 3'd5;
  localparam sector_t SECTOR_6       = 3'd6;
  localparam sector_t SECTOR_INVALID = 3'd7;

  // sqrt(3) in Q1.16.
  localparam int unsigned SQRT3_Q16 = 113512;
  localparam int unsigned SQRT3_W   = 17;
  // Fraction bits of the time values.
  localparam int unsigned TFRAC = 8;
  // Active-time sum is normalized below 2^OVM_SUM_LIMIT before rescaling.
  localparam int unsigned OVM_SUM_LIMIT = 36;

  localparam int unsigned CFG_INDEX_W = 2;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_DC_BUS_VOLTAGE = 2'd0;
  localparam cfg_index_t REG_TIMER_RELOAD   = 2'd1;
  localparam cfg_index_t REG_TOP_MARGIN     = 2'd2;

  localparam int unsigned DC_BUS_RESET = 24000;
  localparam int unsigned RELOAD_RESET = 4250;
  localparam int unsigned MARGIN_RESET = 80;

endpackage

`default_nettype wire

FILE: hw/rtl/svpwm_div2_pipe.sv
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Standalone; carries a sideband vector and a valid bit alongside the data.
`default_nettype none

module svpwm_div2_pipe #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned Q_W   = 8,
  parameter int unsigned SB_W  = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [NUM_W-1:0] num_a_i,
  input  wire logic [NUM_W-1:0] num_b_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic                  out_valid_o,
  output logic [Q_W-1:0]        quo_a_o,
  output logic [Q_W-1:0]        quo_b_o,
  output logic [SB_W-1:0]       sb_o
);

  // One step: shift the next dividend bit into the remainder and subtract if it fits.
  function automatic logic [DEN_W+Q_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                    input logic [Q_W-1:0]   low,
                                                    input logic [DEN_W-1:0] den);
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_n;
    logic [Q_W-1:0]   low_n;
    trial = {rem, low[Q_W-1]};
    fits  = (trial >= {1'b0, den});
    rem_n = fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
    low_n = {low[Q_W-2:0], fits};
    return {rem_n, low_n};
  endfunction

  logic [DEN_W-1:0] rem_a_q [Q_W];
  logic [DEN_W-1:0] rem_b_q [Q_W];
  logic [Q_W-1:0]   low_a_q [Q_W];
  logic [Q_W-1:0]   low_b_q [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [SB_W-1:0]  sb_q    [Q_W];
  logic [Q_W-1:0]   vld_q;

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic [DEN_W-1:0] rem_a_in, rem_b_in, den_in;
    logic [Q_W-1:0]   low_a_in, low_b_in;
    logic [SB_W-1:0]  sb_in;
    logic             vld_in;
    logic [DEN_W+Q_W-1:0] step_a_d, step_b_d;

    if (g == 0) begin : g_first
      // The quotient fits Q_W bits, so the high part of the dividend is below the divisor.
      assign rem_a_in = DEN_W'(num_a_i >> Q_W);
      assign rem_b_in = DEN_W'(num_b_i >> Q_W);
      assign low_a_in = num_a_i[Q_W-1:0];
      assign low_b_in = num_b_i[Q_W-1:0];
      assign den_in   = den_i;
      assign sb_in    = sb_i;
      assign vld_in   = in_valid_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[g-1];
      assign rem_b_in = rem_b_q[g-1];
      assign low_a_in = low_a_q[g-1];
      assign low_b_in = low_b_q[g-1];
      assign den_in   = den_q[g-1];
      assign sb_in    = sb_q[g-1];
      assign vld_in   = vld_q[g-1];
    end

    always_comb begin
      step_a_d = div_step(rem_a_in, low_a_in, den_in);
      step_b_d = div_step(rem_b_in, low_b_in, den_in);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[g] <= step_a_d[DEN_W+Q_W-1:Q_W];
      low_a_q[g] <= step_a_d[Q_W-1:0];
      rem_b_q[g] <= step_b_d[DEN_W+Q_W-1:Q_W];
      low_b_q[g] <= step_b_d[Q_W-1:0];
      den_q[g]   <= den_in;
      sb_q[g]    <= sb_in;
    end
  end

  assign out_valid_o = vld_q[Q_W-1];
  assign quo_a_o     = low_a_q[Q_W-1];
  assign quo_b_o     = low_b_q[Q_W-1];
  assign sb_o        = sb_q[Q_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/svpwm_sector_duty_calc_core.sv
// Top level of the seven-segment SVPWM sector and duty calculator.
// Depends on svpwm_pkg, svpwm_div2_pipe and svpwm_sector_duty_calc_core_macros.svh.
`default_nettype none

// A new alpha/beta vector can be started in every clock cycle: busy_o is always low,
// so each cycle with start_i high is one transaction. Exactly one result per transaction
// appears on the result ports for a single cycle, marked by result_valid_o; the receiver
// cannot stall it, so it must sample on the strobe. Between the input and output registers
// the result passes the two bit-serial pipelined dividers: one for the active times
// (division by the bus voltage) and one for the overmodulation rescale (division by the
// active-time sum). Results leave in order.
// Configuration writes are always accepted (cfg_ready_o is high) and must only be
// issued while no transaction is in flight, since the pipeline reads the registers live.
// A bus voltage of zero is treated as one.
module svpwm_sector_duty_calc_core #(
  parameter int unsigned VOLTAGE_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic signed [VOLTAGE_WIDTH-1:0] v_alpha_i,
  input  wire logic signed [VOLTAGE_WIDTH-1:0] v_beta_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire svpwm_pkg::cfg_index_t           cfg_index_i,
  input  wire logic [(VOLTAGE_WIDTH > TIMER_WIDTH ? VOLTAGE_WIDTH : TIMER_WIDTH)-1:0]
                                               cfg_data_i,
  output logic                                 result_valid_o,
  output svpwm_pkg::sector_t                   sector_o,
  output logic [TIMER_WIDTH-1:0]               duty_a_o,
  output logic [TIMER_WIDTH-1:0]               duty_b_o,
  output logic [TIMER_WIDTH-1:0]               duty_c_o,
  output logic                                 overmodulated_o
);

  import svpwm_pkg::*;

  localparam int unsigned VW   = VOLTAGE_WIDTH;
  localparam int unsigned TW   = TIMER_WIDTH;
  // Signed width of the Q16 voltage terms.
  localparam int unsigned PW   = VW + 19;
  // Magnitude of a voltage term and the rounded sqrt3 product.
  localparam int unsigned MAGW = VW + 18;
  localparam int unsigned PRW  = MAGW + SQRT3_W + 1;
  localparam int unsigned AW   = VW + 19;
  // Active-time dividend before and after dropping the fraction bits.
  localparam int unsigned MW   = AW + TW + 1;
  localparam int unsigned DW   = MW - TFRAC;
  localparam int unsigned SW   = DW + 1;
  localparam int unsigned KW   = $clog2(SW + 1);
  // Period in Q.8 ticks and the rescale dividend.
  localparam int unsigned TSW  = TW + TFRAC + 1;
  localparam int unsigned LIM  = OVM_SUM_LIMIT;
  localparam int unsigned N2W  = LIM + TSW;
  localparam int unsigned SB2W = SECTOR_W + 1 + 2 * TSW;
  localparam int unsigned LAT  = 11 + DW + TSW;

  localparam logic signed [PW-1:0] SQRT3_S = PW'(SQRT3_Q16);

  function automatic logic [MAGW-1:0] mag_of(input logic signed [PW-1:0] w);
    logic [PW-1:0] m;
    m = w[PW-1] ? PW'(-w) : PW'(w);
    return MAGW'(m);
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [VW-1:0] dc_bus_q;
  logic [TW-1:0] reload_q;
  logic [TW-1:0] margin_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_bus_q <= VW'(DC_BUS_RESET);
      reload_q <= TW'(RELOAD_RESET);
      margin_q <= TW'(MARGIN_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DC_BUS_VOLTAGE: dc_bus_q <= VW'(cfg_data_i);
        REG_TIMER_RELOAD:   reload_q <= TW'(cfg_data_i);
        REG_TOP_MARGIN:     margin_q <= TW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [VW-1:0]  udc;
  logic [TSW-1:0] ts;
  logic [TW-1:0]  ceil_lim;

  assign udc      = (dc_bus_q == '0) ? VW'(1) : dc_bus_q;
  assign ts       = TSW'(reload_q) << (TFRAC + 1);
  assign ceil_lim = (reload_q > margin_q) ? TW'(reload_q - margin_q) : '0;

  // ---------------------------------------------------------------- stage 1: input register
  logic                 v1_q;
  logic signed [VW-1:0] ua_q, ub_q;

  // ---------------------------------------------------------------- stage 2: sqrt3 * alpha
  logic                 v2_q;
  logic signed [PW-1:0] p_d, p_q, b16_d, b16_q;

  assign p_d   = PW'(ua_q) * SQRT3_S;
  assign b16_d = PW'(ub_q) <<< 16;

  // ---------------------------------------------------------------- stage 3: sector and terms
  logic                 v3_q;
  logic signed [PW-1:0] dif_b, dif_c, tx_w, ty_w, tz_w, w1, w2;
  logic                 sa, sb, sc;
  sector_t              sec_d, sec3_q;
  logic [MAGW-1:0]      mag1_q, mag2_q;

  always_comb begin
    dif_b = p_q - b16_q;
    dif_c = -p_q - b16_q;
    sa    = !b16_q[PW-1] && (b16_q != '0);
    sb    = !dif_b[PW-1] && (dif_b != '0);
    sc    = !dif_c[PW-1] && (dif_c != '0);
    sec_d = {sc, sb, sa};
    tx_w  = b16_q <<< 1;
    ty_w  = p_q + b16_q;
    tz_w  = b16_q - p_q;
    // Pick the two active-vector terms that this sector uses.
    case (sec_d)
      SECTOR_1: begin w1 = tz_w; w2 = ty_w; end
      SECTOR_2: begin w1 = ty_w; w2 = tx_w; end
      SECTOR_3: begin w1 = tz_w; w2 = tx_w; end
      SECTOR_4: begin w1 = tx_w; w2 = tz_w; end
      SECTOR_5: begin w1 = tx_w; w2 = ty_w; end
      default:  begin w1 = ty_w; w2 = tz_w; end
    endcase
  end

  // ---------------------------------------------------------------- stage 4: round sqrt3 * |w|
  logic            v4_q;
  sector_t         sec4_q;
  logic [AW-1:0]   a1_d, a2_d, a1_q, a2_q;

  assign a1_d = AW'((PRW'(mag1_q) * PRW'(SQRT3_Q16) + PRW'(32768)) >> 16);
  assign a2_d = AW'((PRW'(mag2_q) * PRW'(SQRT3_Q16) + PRW'(32768)) >> 16);

  // ---------------------------------------------------------------- stage 5: times reload
  logic            v5_q;
  sector_t         sec5_q;
  logic [MW-1:0]   m1_d, m2_d, m1_q, m2_q;

  assign m1_d = MW'(a1_q) * MW'(reload_q) + (MW'(udc) << (TFRAC - 1));
  assign m2_d = MW'(a2_q) * MW'(reload_q) + (MW'(udc) << (TFRAC - 1));

  // ---------------------------------------------------------------- divider 1: / Udc
  // Dropping the fraction bits first gives the same floor as dividing by Udc*256.
  logic            d1_valid;
  logic [DW-1:0]   t1_raw, t2_raw;
  sector_t         d1_sec;

  svpwm_div2_pipe #(
    .NUM_W (DW),
    .DEN_W (VW),
    .Q_W   (DW),
    .SB_W  (SECTOR_W)
  ) u_div_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .num_a_i     (m1_q[MW-1:TFRAC]),
    .num_b_i     (m2_q[MW-1:TFRAC]),
    .den_i       (udc),
    .sb_i        (sec5_q),
    .out_valid_o (d1_valid),
    .quo_a_o     (t1_raw),
    .quo_b_o     (t2_raw),
    .sb_o        (d1_sec)
  );

  // ---------------------------------------------------------------- stage 6: sum and compare
  logic            v6_q, ovm6_q;
  sector_t         sec6_q;
  logic [DW-1:0]   t1_6_q, t2_6_q;
  logic [SW-1:0]   s_d, s6_q;

  assign s_d = SW'(t1_raw) + SW'(t2_raw);

  // ---------------------------------------------------------------- stage 7: normalize amount
  logic            v7_q, ovm7_q;
  sector_t         sec7_q;
  logic [DW-1:0]   t1_7_q, t2_7_q;
  logic [SW-1:0]   s7_q;
  logic [KW-1:0]   k_d, k7_q;

  always_comb begin
    k_d = '0;
    for (int i = LIM; i < SW; i++) begin
      if (s6_q[i]) k_d = KW'(i - LIM + 1);
    end
  end

  // ---------------------------------------------------------------- stage 8: shift down
  logic            v8_q, ovm8_q;
  sector_t         sec8_q;
  logic [TSW-1:0]  t1_8_q, t2_8_q;
  logic [LIM-1:0]  t1s_q, t2s_q, ss_q;

  // ---------------------------------------------------------------- stage 9: times period
  logic            v9_q, ovm9_q;
  sector_t         sec9_q;
  logic [TSW-1:0]  t1_9_q, t2_9_q;
  logic [LIM-1:0]  ss9_q;
  logic [N2W-1:0]  n1_q, n2_q;

  // ---------------------------------------------------------------- divider 2: / sum
  logic            d2_valid;
  logic [TSW-1:0]  t1_ovm, t2_ovm;
  logic [SB2W-1:0] d2_sb;

  svpwm_div2_pipe #(
    .NUM_W (N2W),
    .DEN_W (LIM),
    .Q_W   (TSW),
    .SB_W  (SB2W)
  ) u_div_ovm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v9_q),
    .num_a_i     (n1_q),
    .num_b_i     (n2_q),
    .den_i       (ss9_q),
    .sb_i        ({sec9_q, ovm9_q, t1_9_q, t2_9_q}),
    .out_valid_o (d2_valid),
    .quo_a_o     (t1_ovm),
    .quo_b_o     (t2_ovm),
    .sb_o        (d2_sb)
  );

  // ---------------------------------------------------------------- stage 10: compare points
  sector_t         d2_sec;
  logic            d2_ovm;
  logic [TSW-1:0]  t1_plain, t2_plain, t1_f, t2_f, t0_d, tb_d, tc_d;
  logic            v10_q, ovm10_q;
  sector_t         sec10_q;
  logic [TSW-1:0]  t0_q, tb_q, tc_q;

  always_comb begin
    {d2_sec, d2_ovm, t1_plain, t2_plain} = d2_sb;
    t1_f = d2_ovm ? t1_ovm : t1_plain;
    t2_f = d2_ovm ? t2_ovm : t2_plain;
    t0_d = (ts - t1_f - t2_f) >> 2;
    tb_d = t0_d + (t1_f >> 1);
    tc_d = tb_d + (t2_f >> 1);
  end

  // ---------------------------------------------------------------- stage 11: map and clamp
  logic [TSW-1:0]  cm_a, cm_b, cm_c;
  logic [TW-1:0]   da_d, db_d, dc_d;
  logic            zero_vec;

  function automatic logic [TW-1:0] clamp_duty(input logic [TSW-1:0] cm,
                                               input logic [TW-1:0]  lim);
    logic [TW:0] whole;
    whole = (TW + 1)'(cm >> TFRAC);
    return (whole >= (TW + 1)'(lim)) ? lim : TW'(whole);
  endfunction

  always_comb begin
    case (sec10_q)
      SECTOR_1: begin cm_a = tb_q; cm_b = t0_q; cm_c = tc_q; end
      SECTOR_2: begin cm_a = t0_q; cm_b = tc_q; cm_c = tb_q; end
      SECTOR_3: begin cm_a = t0_q; cm_b = tb_q; cm_c = tc_q; end
      SECTOR_4: begin cm_a = tc_q; cm_b = tb_q; cm_c = t0_q; end
      SECTOR_5: begin cm_a = tc_q; cm_b = t0_q; cm_c = tb_q; end
      default:  begin cm_a = tb_q; cm_b = tc_q; cm_c = t0_q; end
    endcase
    // A zero vector has no sector; everything reads as zero.
    zero_vec = (sec10_q == SECTOR_NONE) || (sec10_q == SECTOR_INVALID);
    da_d = zero_vec ? '0 : clamp_duty(cm_a, ceil_lim);
    db_d = zero_vec ? '0 : clamp_duty(cm_b, ceil_lim);
    dc_d = zero_vec ? '0 : clamp_duty(cm_c, ceil_lim);
  end

  logic            v11_q, ovm11_q;
  sector_t         sec11_q;
  logic [TW-1:0]   da_q, db_q, dc_q;

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      v1_q  <= start_i && !busy_o;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= d1_valid;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= d2_valid;
      v11_q <= v10_q;
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    ua_q    <= v_alpha_i;
    ub_q    <= v_beta_i;
    p_q     <= p_d;
    b16_q   <= b16_d;
    sec3_q  <= sec_d;
    mag1_q  <= mag_of(w1);
    mag2_q  <= mag_of(w2);
    sec4_q  <= sec3_q;
    a1_q    <= a1_d;
    a2_q    <= a2_d;
    sec5_q  <= sec4_q;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    sec6_q  <= d1_sec;
    t1_6_q  <= t1_raw;
    t2_6_q  <= t2_raw;
    s6_q    <= s_d;
    ovm6_q  <= (s_d > SW'(ts));
    sec7_q  <= sec6_q;
    ovm7_q  <= ovm6_q;
    t1_7_q  <= t1_6_q;
    t2_7_q  <= t2_6_q;
    s7_q    <= s6_q;
    k7_q    <= k_d;
    // Without overmodulation the times fit the period width.
    sec8_q  <= sec7_q;
    ovm8_q  <= ovm7_q;
    t1_8_q  <= TSW'(t1_7_q);
    t2_8_q  <= TSW'(t2_7_q);
    t1s_q   <= LIM'(t1_7_q >> k7_q);
    t2s_q   <= LIM'(t2_7_q >> k7_q);
    ss_q    <= LIM'(s7_q >> k7_q);
    sec9_q  <= sec8_q;
    ovm9_q  <= ovm8_q;
    t1_9_q  <= t1_8_q;
    t2_9_q  <= t2_8_q;
    ss9_q   <= ss_q;
    n1_q    <= N2W'(t1s_q) * N2W'(ts);
    n2_q    <= N2W'(t2s_q) * N2W'(ts);
    sec10_q <= d2_sec;
    ovm10_q <= d2_ovm;
    t0_q    <= t0_d;
    tb_q    <= tb_d;
    tc_q    <= tc_d;
    sec11_q <= zero_vec ? SECTOR_NONE : sec10_q;
    ovm11_q <= zero_vec ? 1'b0 : ovm10_q;
    da_q    <= da_d;
    db_q    <= db_d;
    dc_q    <= dc_d;
  end

  assign result_valid_o  = v11_q;
  assign sector_o        = sec11_q;
  assign duty_a_o        = da_q;
  assign duty_b_o        = db_q;
  assign duty_c_o        = dc_q;
  assign overmodulated_o = ovm11_q;

  // ---------------------------------------------------------------- assertions
`include "svpwm_sector_duty_calc_core_macros.svh"

  `SVPWM_ASSERT_IMP(a_zero_sector_quiet, result_valid_o && (sector_o == SECTOR_NONE), (duty_a_o == '0) && (duty_b_o == '0) && (duty_c_o == '0) && !overmodulated_o)
  `SVPWM_ASSERT_IMP(a_duty_below_ceiling, result_valid_o, (duty_a_o <= ceil_lim) && (duty_b_o <= ceil_lim) && (duty_c_o <= ceil_lim))
  `SVPWM_ASSERT_IMP(a_fixed_latency, result_valid_o, $past(start_i, LAT))
  `SVPWM_ASSERT_NXT(a_ovm_needs_sector, v10_q && ovm10_q && !zero_vec, overmodulated_o && (sector_o != SECTOR_NONE))

endmodule

`default_nettype wire
